/* sv/qvr_pkg.sv */
// Shared types and constants for the quaternion vector rotate unit.
// Holds the quaternion struct, register indexes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package qvr_pkg;

  localparam int QW         = 18;
  localparam int AXIS_W     = 16;
  localparam int ANGLE_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CW         = 34;
  localparam int ATAN_IDX_W = 5;
  localparam int FRAC       = 14;
  localparam int RND_HALF   = 8192;

  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [CW-1:0] TRIG_HALF    = 34'sd32768;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 8'd3;

  typedef struct packed {
    logic signed [QW-1:0] a;
    logic signed [QW-1:0] b;
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] d;
  } qvr_quat_t;

  function automatic logic [31:0] atan_at(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    v = 32'h0;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/quaternion_vector_rotate_unit.sv */
// Top level of the quaternion vector rotate unit: stream ports and config port.
// Instantiates qvr_trig and qvr_sandwich; depends on qvr_pkg.
//
// Rotates one Q4.12 vector per clock, while the output is not held and the quaternion
// is ready, about the configured axis by the configured angle; each request passes
// through the four-stage multiply pipeline, which halts as a whole while the output
// is held. After reset and after every configuration write, s_tready stays low while
// the shared CORDIC iterates once a cycle and the quaternion is scaled.
`default_nettype none

module quaternion_vector_rotate_unit #(
  parameter int VEC_WIDTH       = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // vec_x, vec_y, vec_z, then zero padding
  input  wire logic [((3*VEC_WIDTH+7)/8)*8-1:0]  s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // rot_x, rot_y, rot_z, then zero padding
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0]       m_tdata
);

  localparam int VW  = VEC_WIDTH;
  localparam int TDW = ((3*VEC_WIDTH+7)/8)*8;

  qvr_pkg::qvr_quat_t    quat;
  logic                  quat_ready;
  logic                  en;
  logic signed [VW-1:0]  rot_x, rot_y, rot_z;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en && quat_ready;
  assign m_tdata   = TDW'({rot_z, rot_y, rot_x});

  qvr_trig #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .quat      (quat),
    .quat_ready(quat_ready)
  );

  qvr_sandwich #(
    .VW(VW)
  ) u_sandwich (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid && s_tready),
    .vec_x    (s_tdata[VW-1:0]),
    .vec_y    (s_tdata[2*VW-1:VW]),
    .vec_z    (s_tdata[3*VW-1:2*VW]),
    .quat     (quat),
    .out_valid(m_tvalid),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z)
  );

  a_ready_needs_quat: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> quat_ready)
    else $error("quaternion_vector_rotate_unit: request taken without quaternion");

  a_cfg_drops_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("quaternion_vector_rotate_unit: ready high right after config write");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("quaternion_vector_rotate_unit: input taken while pipeline stalled");

endmodule

`default_nettype wire

/* sv/qvr_trig.sv */
// Configuration registers and rotation quaternion generator.
// Iterative CORDIC, one step a cycle, then scales sin by the axis.
// Depends on qvr_pkg.
`default_nettype none

module qvr_trig #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [qvr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qvr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output qvr_pkg::qvr_quat_t                    quat,
  output logic                                  quat_ready
);

  localparam int IW  = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
  localparam int CW  = qvr_pkg::CW;
  localparam int QW  = qvr_pkg::QW;
  localparam int SW  = QW + qvr_pkg::AXIS_W;

  typedef enum logic [2:0] {T_LOAD, T_RUN, T_ROUND, T_SCALE, T_DONE} trig_state_t;

  trig_state_t state;
  logic signed [qvr_pkg::AXIS_W-1:0] axis_x, axis_y, axis_z;
  logic [qvr_pkg::ANGLE_W-1:0]       angle;
  logic signed [CW-1:0]              x, y, z;
  logic                              flip;
  logic [IW-1:0]                     iter;
  logic signed [QW-1:0]              cos_h, sin_h;

  logic signed [CW-1:0] phase, atan_v, x_neg, y_neg, x_rnd, y_rnd;
  logic signed [SW-1:0] sx, sy, sz;

  always_comb begin
    phase  = CW'({angle, 15'b0});
    atan_v = CW'(qvr_pkg::atan_at(qvr_pkg::ATAN_IDX_W'(iter)));
    x_neg  = flip ? -x : x;
    y_neg  = flip ? -y : y;
    x_rnd  = (x_neg + qvr_pkg::TRIG_HALF) >>> 16;
    y_rnd  = (y_neg + qvr_pkg::TRIG_HALF) >>> 16;
    sx     = (SW'(sin_h) * SW'(axis_x) + SW'(qvr_pkg::RND_HALF)) >>> qvr_pkg::FRAC;
    sy     = (SW'(sin_h) * SW'(axis_y) + SW'(qvr_pkg::RND_HALF)) >>> qvr_pkg::FRAC;
    sz     = (SW'(sin_h) * SW'(axis_z) + SW'(qvr_pkg::RND_HALF)) >>> qvr_pkg::FRAC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_LOAD;
      axis_x <= 16'sd16384;
      axis_y <= '0;
      axis_z <= '0;
      angle  <= '0;
      iter   <= '0;
      flip   <= 1'b0;
    end else if (cfg_we) begin
      state <= T_LOAD;
      unique case (cfg_index)
        qvr_pkg::REG_AXIS_X: axis_x <= cfg_data;
        qvr_pkg::REG_AXIS_Y: axis_y <= cfg_data;
        qvr_pkg::REG_AXIS_Z: axis_z <= cfg_data;
        qvr_pkg::REG_ANGLE:  angle  <= cfg_data;
        default: ;
      endcase
    end else begin
      unique case (state)
        T_LOAD: begin
          x    <= qvr_pkg::CORDIC_GAIN;
          y    <= '0;
          iter <= '0;
          if (phase > qvr_pkg::QUARTER_TURN) begin
            z    <= phase - qvr_pkg::HALF_TURN;
            flip <= 1'b1;
          end else begin
            z    <= phase;
            flip <= 1'b0;
          end
          state <= T_RUN;
        end
        T_RUN: begin
          if (!z[CW-1]) begin
            x <= x - (y >>> iter);
            y <= y + (x >>> iter);
            z <= z - atan_v;
          end else begin
            x <= x + (y >>> iter);
            y <= y - (x >>> iter);
            z <= z + atan_v;
          end
          iter <= iter + 1'b1;
          if (iter == IW'(TRIG_ITERATIONS - 1)) state <= T_ROUND;
        end
        T_ROUND: begin
          cos_h <= x_rnd[QW-1:0];
          sin_h <= y_rnd[QW-1:0];
          state <= T_SCALE;
        end
        T_SCALE: begin
          quat.a <= cos_h;
          quat.b <= sx[QW-1:0];
          quat.c <= sy[QW-1:0];
          quat.d <= sz[QW-1:0];
          state  <= T_DONE;
        end
        T_DONE: ;
        default: state <= T_LOAD;
      endcase
    end
  end

  assign quat_ready = (state == T_DONE);

endmodule

`default_nettype wire

/* sv/qvr_sandwich.sv */
// Four-stage pipeline for the quaternion product q * v * conj(q).
// Products, rounded q*v, products with conj(q), rounded and saturated result.
// Depends on qvr_pkg.
`default_nettype none

module qvr_sandwich #(
  parameter int VW = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [VW-1:0]     vec_x,
  input  wire logic signed [VW-1:0]     vec_y,
  input  wire logic signed [VW-1:0]     vec_z,
  input  wire qvr_pkg::qvr_quat_t       quat,
  output logic                          out_valid,
  output logic signed [VW-1:0]          rot_x,
  output logic signed [VW-1:0]          rot_y,
  output logic signed [VW-1:0]          rot_z
);

  localparam int QW  = qvr_pkg::QW;
  localparam int FR  = qvr_pkg::FRAC;
  localparam int M1W = QW + VW;
  localparam int S1W = M1W + 2;
  localparam int PW  = S1W - FR;
  localparam int M2W = PW + QW;
  localparam int S2W = M2W + 2;
  localparam int RW  = S2W - FR;

  logic v1, v2, v3;
  logic signed [M1W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;
  logic signed [PW-1:0]  pa, pb, pc, pd;
  logic signed [M2W-1:0] pa_b, pa_c, pa_d, pb_a, pb_c, pb_d;
  logic signed [M2W-1:0] pc_a, pc_b, pc_d, pd_a, pd_b, pd_c;

  logic signed [S1W-1:0] sa, sb, sc, sd;
  logic signed [S2W-1:0] s0, s1, s2;

  function automatic logic signed [VW-1:0] sat(input logic signed [S2W-1:0] s);
    logic [RW-1:0] r;
    logic [RW-VW:0] hi;
    r  = s[S2W-1:FR];
    hi = r[RW-1:VW-1];
    if (hi == '0 || hi == '1) return r[VW-1:0];
    return r[RW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  always_comb begin
    sa = -S1W'(bx) - S1W'(cy) - S1W'(dz) + S1W'(qvr_pkg::RND_HALF);
    sb =  S1W'(ax) + S1W'(cz) - S1W'(dy) + S1W'(qvr_pkg::RND_HALF);
    sc =  S1W'(ay) + S1W'(dx) - S1W'(bz) + S1W'(qvr_pkg::RND_HALF);
    sd =  S1W'(az) + S1W'(by) - S1W'(cx) + S1W'(qvr_pkg::RND_HALF);
    s0 = -S2W'(pa_b) + S2W'(pb_a) - S2W'(pc_d) + S2W'(pd_c) + S2W'(qvr_pkg::RND_HALF);
    s1 = -S2W'(pa_c) + S2W'(pc_a) - S2W'(pd_b) + S2W'(pb_d) + S2W'(qvr_pkg::RND_HALF);
    s2 = -S2W'(pa_d) + S2W'(pd_a) - S2W'(pb_c) + S2W'(pc_b) + S2W'(qvr_pkg::RND_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= M1W'(quat.a) * M1W'(vec_x);
      ay <= M1W'(quat.a) * M1W'(vec_y);
      az <= M1W'(quat.a) * M1W'(vec_z);
      bx <= M1W'(quat.b) * M1W'(vec_x);
      by <= M1W'(quat.b) * M1W'(vec_y);
      bz <= M1W'(quat.b) * M1W'(vec_z);
      cx <= M1W'(quat.c) * M1W'(vec_x);
      cy <= M1W'(quat.c) * M1W'(vec_y);
      cz <= M1W'(quat.c) * M1W'(vec_z);
      dx <= M1W'(quat.d) * M1W'(vec_x);
      dy <= M1W'(quat.d) * M1W'(vec_y);
      dz <= M1W'(quat.d) * M1W'(vec_z);

      pa <= sa[S1W-1:FR];
      pb <= sb[S1W-1:FR];
      pc <= sc[S1W-1:FR];
      pd <= sd[S1W-1:FR];

      pa_b <= M2W'(pa) * M2W'(quat.b);
      pa_c <= M2W'(pa) * M2W'(quat.c);
      pa_d <= M2W'(pa) * M2W'(quat.d);
      pb_a <= M2W'(pb) * M2W'(quat.a);
      pb_c <= M2W'(pb) * M2W'(quat.c);
      pb_d <= M2W'(pb) * M2W'(quat.d);
      pc_a <= M2W'(pc) * M2W'(quat.a);
      pc_b <= M2W'(pc) * M2W'(quat.b);
      pc_d <= M2W'(pc) * M2W'(quat.d);
      pd_a <= M2W'(pd) * M2W'(quat.a);
      pd_b <= M2W'(pd) * M2W'(quat.b);
      pd_c <= M2W'(pd) * M2W'(quat.c);

      rot_x <= sat(s0);
      rot_y <= sat(s1);
      rot_z <= sat(s2);
    end
  end

  a_first_stage_loads: assert property (@(posedge clk) disable iff (rst)
    en |=> (v1 == $past(in_valid)))
    else $error("qvr_sandwich: first-stage valid does not follow the request");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    en && v3 |=> out_valid)
    else $error("qvr_sandwich: third-stage request not moved to output");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> (v1 == $past(v1)) && (v2 == $past(v2)) && (v3 == $past(v3)))
    else $error("qvr_sandwich: stage valid changed during stall");

endmodule

`default_nettype wire

/* bench/qvr_rotate_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the quaternion vector rotate unit: tracks the register writes, works out the
// rotated vector for every accepted request and compares it with what leaves the master side.
// Depends on qvr_pkg for the register indexes and config widths only; the arithmetic is its own.

module qvr_rotate_checker #(
  parameter int VEC_WIDTH       = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [((3*VEC_WIDTH+7)/8)*8-1:0]  s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [((3*VEC_WIDTH+7)/8)*8-1:0]  m_tdata,
  output int                                pending,
  output int                                fails,
  output int                                checked
);

  localparam int     ATAN_DEPTH      = 24;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint QUARTER_TURN    = 64'sd1073741824;
  localparam longint HALF_TURN       = 64'sd2147483648;
  localparam longint PHASE_SCALE     = 64'sd32768;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] z;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [VEC_WIDTH-1:0] x;
  } rot_vec_t;

  longint arctan_step [ATAN_DEPTH] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic signed [15:0] axis_x_q = 16'sd16384;
  logic signed [15:0] axis_y_q = 16'sd0;
  logic signed [15:0] axis_z_q = 16'sd0;
  logic        [15:0] angle_q  = 16'd0;

  rot_vec_t rot_expect_q [$];
  rot_vec_t want;
  rot_vec_t got;

  initial begin
    pending = 0;
    fails   = 0;
    checked = 0;
  end

  function automatic longint round_q(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] saturate(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (VEC_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[VEC_WIDTH-1:0];
  endfunction

  // cos and sin of half the configured angle, Q14
  function automatic void half_angle_cos_sin(output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    z    = longint'(angle_q) * PHASE_SCALE;
    x    = CORDIC_GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z    = z - HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_ITERATIONS && i < ATAN_DEPTH; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_step[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_step[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_q(x, 16);
    s = round_q(y, 16);
  endfunction

  function automatic rot_vec_t rotate_vector(input logic signed [VEC_WIDTH-1:0] vx,
                                             input logic signed [VEC_WIDTH-1:0] vy,
                                             input logic signed [VEC_WIDTH-1:0] vz);
    longint   qa, qb, qc, qd;
    longint   vb, vc, vd;
    longint   pa, pb, pc, pd;
    longint   s;
    longint   r0, r1, r2;
    rot_vec_t res;
    half_angle_cos_sin(qa, s);
    qb = round_q(s * longint'(axis_x_q), 14);
    qc = round_q(s * longint'(axis_y_q), 14);
    qd = round_q(s * longint'(axis_z_q), 14);
    vb = longint'(vx);
    vc = longint'(vy);
    vd = longint'(vz);
    pa = round_q(-qb * vb - qc * vc - qd * vd, 14);
    pb = round_q(qa * vb + qc * vd - vc * qd, 14);
    pc = round_q(qa * vc + vb * qd - qb * vd, 14);
    pd = round_q(qa * vd + qb * vc - qc * vb, 14);
    r0 = -pa * qb + pb * qa - pc * qd + pd * qc;
    r1 = -pa * qc + pc * qa - pd * qb + pb * qd;
    r2 = -pa * qd + pd * qa - pb * qc + pc * qb;
    res.x = saturate(round_q(r0, 14));
    res.y = saturate(round_q(r1, 14));
    res.z = saturate(round_q(r2, 14));
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      axis_x_q = 16'sd16384;
      axis_y_q = 16'sd0;
      axis_z_q = 16'sd0;
      angle_q  = 16'd0;
      rot_expect_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qvr_pkg::REG_AXIS_X: axis_x_q = cfg_data;
          qvr_pkg::REG_AXIS_Y: axis_y_q = cfg_data;
          qvr_pkg::REG_AXIS_Z: axis_z_q = cfg_data;
          qvr_pkg::REG_ANGLE:  angle_q  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        rot_expect_q.push_back(rotate_vector(s_tdata[VEC_WIDTH-1:0],
                                             s_tdata[2*VEC_WIDTH-1:VEC_WIDTH],
                                             s_tdata[3*VEC_WIDTH-1:2*VEC_WIDTH]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[3*VEC_WIDTH-1:0];
        if (rot_expect_q.size() == 0) begin
          $error("rotated vector with no request outstanding: x %0d y %0d z %0d",
                 got.x, got.y, got.z);
          fails++;
        end else begin
          want = rot_expect_q.pop_front();
          checked++;
          if (got.x !== want.x) begin
            $error("rot_x: expected %0d, got %0d", want.x, got.x);
            fails++;
          end
          if (got.y !== want.y) begin
            $error("rot_y: expected %0d, got %0d", want.y, got.y);
            fails++;
          end
          if (got.z !== want.z) begin
            $error("rot_z: expected %0d, got %0d", want.z, got.z);
            fails++;
          end
        end
      end
      pending <= rot_expect_q.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the bench for quaternion_vector_rotate_unit: clock, reset, register writes and vector
// requests with random idling on both sides. Depends on qvr_pkg and qvr_rotate_checker.

module tb;

  localparam int VW          = 16;
  localparam int TRIG_ITER   = 16;
  localparam int DW          = ((3*VW+7)/8)*8;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int DRAIN_WAIT  = 16;

  localparam logic [qvr_pkg::CFG_IDX_W-1:0] REG_NONE_LOW  = 8'd4;
  localparam logic [qvr_pkg::CFG_IDX_W-1:0] REG_NONE_HIGH = 8'hFF;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                              s_tvalid  = 1'b0;
  logic [DW-1:0]                     s_tdata   = '0;
  logic                              m_tready  = 1'b0;
  logic                              cfg_ready;
  logic                              s_tready;
  logic                              m_tvalid;
  logic [DW-1:0]                     m_tdata;

  int pending;
  int fails;
  int checked;
  int cycle_count = 0;
  int n_settings  = 0;
  bit idle_on     = 1'b1;
  bit hold_req    = 1'b0;

  quaternion_vector_rotate_unit #(
    .VEC_WIDTH       (VW),
    .TRIG_ITERATIONS (TRIG_ITER)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  qvr_rotate_checker #(
    .VEC_WIDTH       (VW),
    .TRIG_ITERATIONS (TRIG_ITER)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .pending   (pending),
    .fails     (fails),
    .checked   (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [VW-1:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return VW'($urandom);
      1: return VW'($urandom_range(0, 8192)) - VW'(4096);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return VW'($urandom_range(0, 32768)) - VW'(16384);
    endcase
  endfunction

  task automatic send_vec(input logic [VW-1:0] x, input logic [VW-1:0] y,
                          input logic [VW-1:0] z);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_reg(input logic [qvr_pkg::CFG_IDX_W-1:0] idx,
                         input logic [qvr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int          a, b, c, pick;
    real         norm;
    logic [15:0] ax, ay, az, ang;
    logic [15:0] special_angles [8];

    special_angles = '{16'd0, 16'd1, 16'd16384, 16'd32767,
                       16'd32768, 16'd32769, 16'd49152, 16'd65535};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    n_settings = 1;

    // identity setting from reset: field extremes
    send_vec(16'h0000, 16'h0000, 16'h0000);
    send_vec(16'h7FFF, 16'h0000, 16'h0000);
    send_vec(16'h8000, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h7FFF, 16'h0000);
    send_vec(16'h0000, 16'h8000, 16'h0000);
    send_vec(16'h0000, 16'h0000, 16'h7FFF);
    send_vec(16'h0000, 16'h0000, 16'h8000);
    send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    send_vec(16'hFFFF, 16'h1000, 16'hAAAA);

    // quarter turn about z
    drain();
    set_reg(qvr_pkg::REG_AXIS_X, 16'h0000);
    set_reg(qvr_pkg::REG_AXIS_Z, 16'd16384);
    set_reg(qvr_pkg::REG_ANGLE, 16'd16384);
    close_cfg();
    send_vec(16'h1000, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h1000, 16'h0000);
    send_vec(16'h5555, 16'hAAAA, 16'h1234);

    // non-unit axis, half turn: drive saturation
    drain();
    set_reg(qvr_pkg::REG_AXIS_X, 16'd16384);
    set_reg(qvr_pkg::REG_AXIS_Y, 16'd16384);
    set_reg(qvr_pkg::REG_AXIS_Z, 16'd16384);
    set_reg(qvr_pkg::REG_ANGLE, 16'd32768);
    close_cfg();
    send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vec(16'h8000, 16'h1000, 16'h7FFF);
    send_vec(16'h1000, 16'h2000, 16'h3000);

    // most negative axis component, full angle; writes to absent registers must be dropped
    drain();
    set_reg(qvr_pkg::REG_AXIS_X, 16'h8000);
    set_reg(qvr_pkg::REG_AXIS_Y, 16'h0000);
    set_reg(qvr_pkg::REG_AXIS_Z, 16'h0000);
    set_reg(qvr_pkg::REG_ANGLE, 16'hFFFF);
    set_reg(REG_NONE_LOW, 16'hFFFF);
    set_reg(REG_NONE_HIGH, 16'h0000);
    close_cfg();
    send_vec(16'h1000, 16'h1000, 16'h1000);
    send_vec(16'h7FFF, 16'h8000, 16'h0001);

    // just past the quarter-turn fold of the half angle
    drain();
    set_reg(qvr_pkg::REG_AXIS_X, 16'h0000);
    set_reg(qvr_pkg::REG_AXIS_Y, 16'd16384);
    set_reg(qvr_pkg::REG_ANGLE, 16'd32769);
    close_cfg();
    send_vec(16'h1000, 16'h0800, 16'hF000);
    send_vec(16'h8000, 16'h7FFF, 16'h8000);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        ax = 16'h0000;
        ay = 16'h0000;
        az = 16'h0000;
        a  = $urandom_range(0, 2);
        b  = ($urandom_range(0, 1) == 0) ? 16384 : -16384;
        if (a == 0) ax = 16'(b);
        else if (a == 1) ay = 16'(b);
        else az = 16'(b);
      end else if (pick < 8) begin
        a = $urandom_range(0, 4000) - 2000;
        b = $urandom_range(0, 4000) - 2000;
        c = $urandom_range(0, 4000) - 2000;
        if (a == 0 && b == 0 && c == 0) a = 1;
        norm = $sqrt(real'(a * a + b * b + c * c));
        ax = 16'($rtoi(16384.0 * a / norm));
        ay = 16'($rtoi(16384.0 * b / norm));
        az = 16'($rtoi(16384.0 * c / norm));
      end else if (pick == 8) begin
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
      end else begin
        ax = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h4000;
        ay = ($urandom_range(0, 1) == 0) ? 16'hC000 : 16'h0000;
        az = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h4000;
      end
      ang = ($urandom_range(0, 2) == 0) ? special_angles[3'($urandom_range(0, 7))]
                                        : 16'($urandom);
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        set_reg(qvr_pkg::REG_AXIS_X, ax);
        set_reg(qvr_pkg::REG_AXIS_Y, ay);
        set_reg(qvr_pkg::REG_AXIS_Z, az);
      end
      if ($urandom_range(0, 5) == 0)
        set_reg(($urandom_range(0, 1) == 0) ? REG_NONE_LOW : REG_NONE_HIGH, 16'($urandom));
      set_reg(qvr_pkg::REG_ANGLE, ang);
      close_cfg();
      idle_on = !(ph == RAND_PHASES / 2 || ph == RAND_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 20)
          hold_req <= 1'b1;
        send_vec(rand_comp(), rand_comp(), rand_comp());
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Checked %0d rotated vectors over %0d register settings,", checked, n_settings);
    $display("with random stalls on both sides and one %0d-cycle output hold-off.", HOLD_CYCLES);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/qvr_pkg.sv
sv/qvr_trig.sv
sv/qvr_sandwich.sv
sv/quaternion_vector_rotate_unit.sv
bench/qvr_rotate_checker.sv
bench/tb.sv
